// ===== design/afu_pkg.sv =====
package afu_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MODE_W    = 3;
  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int ROM_IDX_W = 8;
  localparam int SIG_W     = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    FN_RELU    = 2'd0,
    FN_SIGMOID = 2'd1,
    FN_TANH    = 2'd2,
    FN_LINEAR  = 2'd3
  } func_t;

  // Lower half of the sigmoid curve: entry m is round(ONE / (1 + exp(m/16))).
  // The upper half follows from sigmoid(x) = ONE - sigmoid(-x).
  localparam logic [11:0] SIG_HALF [0:128] = '{
    12'd2048,
    12'd1984, 12'd1920, 12'd1857, 12'd1793, 12'd1731, 12'd1668, 12'd1607, 12'd1546,
    12'd1487, 12'd1428, 12'd1370, 12'd1314, 12'd1259, 12'd1205, 12'd1153, 12'd1102,
    12'd1052, 12'd1004, 12'd957,  12'd912,  12'd869,  12'd827,  12'd786,  12'd747,
    12'd710,  12'd674,  12'd639,  12'd606,  12'd575,  12'd545,  12'd516,  12'd488,
    12'd462,  12'd437,  12'd413,  12'd391,  12'd369,  12'd349,  12'd329,  12'd311,
    12'd293,  12'd277,  12'd261,  12'd246,  12'd232,  12'd219,  12'd206,  12'd194,
    12'd183,  12'd172,  12'd162,  12'd153,  12'd144,  12'd136,  12'd128,  12'd120,
    12'd113,  12'd106,  12'd100,  12'd94,   12'd89,   12'd83,   12'd78,   12'd74,
    12'd69,   12'd65,   12'd61,   12'd58,   12'd54,   12'd51,   12'd48,   12'd45,
    12'd42,   12'd40,   12'd37,   12'd35,   12'd33,   12'd31,   12'd29,   12'd27,
    12'd26,   12'd24,   12'd23,   12'd21,   12'd20,   12'd19,   12'd18,   12'd17,
    12'd16,   12'd15,   12'd14,   12'd13,   12'd12,   12'd11,   12'd11,   12'd10,
    12'd10,   12'd9,    12'd8,    12'd8,    12'd7,    12'd7,    12'd7,    12'd6,
    12'd6,    12'd5,    12'd5,    12'd5,    12'd5,    12'd4,    12'd4,    12'd4,
    12'd4,    12'd3,    12'd3,    12'd3,    12'd3,    12'd3,    12'd2,    12'd2,
    12'd2,    12'd2,    12'd2,    12'd2,    12'd2,    12'd2,    12'd1,    12'd1
  };

  // Full 256-entry sigmoid table, built from the stored half.
  function automatic logic [SIG_W-1:0] sig_lookup(input logic [ROM_IDX_W-1:0] idx);
    logic [ROM_IDX_W-1:0] pos;
    logic [SIG_W-1:0]     val;
    pos = 8'd128 - idx;
    if (idx[7]) begin
      val = SIG_W'(ONE) - {1'b0, SIG_HALF[{1'b0, idx[6:0]}]};
    end else begin
      val = {1'b0, SIG_HALF[pos]};
    end
    return val;
  endfunction

endpackage

// ===== design/afu_core.sv =====
module afu_core
  import afu_pkg::*;
(
  input  logic [MODE_W-1:0]          mode,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0] result
);

  func_t                   fn;
  logic                    deriv;
  logic                    is_pos;
  logic [ROM_IDX_W-1:0]    sig_idx;
  logic [ROM_IDX_W-1:0]    tanh_idx;
  logic signed [SAMPLE_W-1:0] dbl;
  logic [SIG_W-1:0]        sg;
  logic [SIG_W-1:0]        tg;
  logic [SIG_W+1:0]        th_w;
  logic signed [SIG_W:0]   th;
  logic [SIG_W:0]          th_neg;
  logic [SIG_W-1:0]        th_abs;
  logic [SIG_W-1:0]        mul_a;
  logic [SIG_W-1:0]        mul_b;
  logic [2*SIG_W-1:0]      prod;
  logic [SIG_W:0]          prod_sh;

  assign fn     = func_t'(mode[1:0]);
  assign deriv  = mode[2];
  assign is_pos = !sample[SAMPLE_W-1] && (sample != '0);

  // Adding 32768 and keeping the top eight bits is an inversion of the sign bit.
  assign sig_idx = {~sample[SAMPLE_W-1], sample[SAMPLE_W-2:SAMPLE_W-8]};

  // Doubled sample for tanh, saturated when the shift would overflow.
  always_comb begin
    if (sample[SAMPLE_W-1] != sample[SAMPLE_W-2]) begin
      dbl = sample[SAMPLE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      dbl = {sample[SAMPLE_W-2:0], 1'b0};
    end
  end

  assign tanh_idx = {~dbl[SAMPLE_W-1], dbl[SAMPLE_W-2:SAMPLE_W-8]};

  assign sg = sig_lookup(sig_idx);
  assign tg = sig_lookup(tanh_idx);

  assign th_w   = {1'b0, tg, 1'b0} - (SIG_W+2)'(ONE);
  assign th     = th_w[SIG_W:0];
  assign th_neg = -th_w[SIG_W:0];
  assign th_abs = th[SIG_W] ? th_neg[SIG_W-1:0] : th[SIG_W-1:0];

  // One multiplier serves both derivatives.
  assign mul_a   = (fn == FN_SIGMOID) ? sg : th_abs;
  assign mul_b   = (fn == FN_SIGMOID) ? (SIG_W'(ONE) - sg) : th_abs;
  assign prod    = mul_a * mul_b;
  assign prod_sh = prod[2*SIG_W-1:FRAC_BITS];

  always_comb begin
    unique case (fn)
      FN_RELU: begin
        if (deriv) begin
          result = is_pos ? SAMPLE_W'(ONE) : '0;
        end else begin
          result = is_pos ? sample : '0;
        end
      end
      FN_SIGMOID: begin
        result = deriv ? {{(SAMPLE_W-SIG_W-1){1'b0}}, prod_sh}
                       : {{(SAMPLE_W-SIG_W){1'b0}}, sg};
      end
      FN_TANH: begin
        result = deriv ? (SAMPLE_W'(ONE) - {{(SAMPLE_W-SIG_W-1){1'b0}}, prod_sh})
                       : {{(SAMPLE_W-SIG_W-1){th[SIG_W]}}, th};
      end
      FN_LINEAR: begin
        result = deriv ? SAMPLE_W'(ONE) : sample;
      end
      default: begin
        result = sample;
      end
    endcase
  end

endmodule

// ===== design/activation_function_unit.sv =====
// An accepted word passes through the input register and then the result register to out_*.
// Throughput: one word per cycle; the input register takes a new word in the same
// cycle that it hands its word on, and only a stalled result with both registers full
// holds the input off.
// Reset: synchronous, active low; it empties both register stages, so no result
// is pending afterwards.
module activation_function_unit
  import afu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_activation_out
);

  logic                       stg_vld_r;
  logic [MODE_W-1:0]          mode_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       out_vld_r;
  logic signed [SAMPLE_W-1:0] act_r;
  logic signed [SAMPLE_W-1:0] act_nxt;
  logic                       advance;
  logic                       in_take;

  // The input stage moves on whenever the result register is free or drained.
  assign advance  = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  afu_core u_core (
    .mode   (mode_r),
    .sample (sample_r),
    .result (act_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r   <= in_mode;
      sample_r <= in_sample;
    end
    if (advance) begin
      act_r <= act_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_activation_out = act_r;

  a_fill_output: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !out_vld_r |=> out_vld_r)
    else $error("staged word did not reach the result register");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stg_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_linear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !mode_r[2] && (mode_r[1:0] == FN_LINEAR) |=> act_r == $past(sample_r))
    else $error("linear mode did not pass the sample through");

  a_relu_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (mode_r[1:0] == FN_RELU) |=> !act_r[SAMPLE_W-1])
    else $error("relu result is negative");

endmodule

// ===== bench/tb_activation_function_unit.sv =====
module tb_activation_function_unit
  import afu_pkg::*;
();

  localparam int DERIV_BIT  = 2;
  localparam int RAND_WORDS = 1350;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample;
  } act_word_t;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] value;
  } act_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [MODE_W-1:0]          in_mode = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_activation_out;

  act_word_t   send_queue[$];
  act_result_t awaited_results[$];
  int          sigmoid_rom [0:255];

  int in_gap = 0;
  int out_stall = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int error_count = 0;
  int words_checked = 0;
  int deriv_checked = 0;

  activation_function_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_activation_out (out_activation_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Mostly short gaps, a few long ones; a calm stretch has none at all.
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) begin
      return 0;
    end
    if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // The table is indexed by the sample offset to unsigned, top eight bits.
  // The lower half is rounded directly and the upper half mirrored from it.
  function automatic void build_sigmoid_rom();
    real x;
    int  y;
    for (int k = 0; k < 256; k++) begin
      x = (k - 128) / 16.0;
      if (x < 0.0) begin
        x = -x;
      end
      y = $rtoi(4096.0 / (1.0 + $exp(x)) + 0.5);
      sigmoid_rom[k] = (k < 128) ? y : ONE - y;
    end
  endfunction

  function automatic int sigmoid_of(logic signed [SAMPLE_W-1:0] v);
    return sigmoid_rom[{~v[SAMPLE_W-1], v[SAMPLE_W-2:SAMPLE_W-8]}];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_activation(
      logic [MODE_W-1:0] mode, logic signed [SAMPLE_W-1:0] sample);
    bit deriv;
    int s;
    int sg;
    int dbl;
    int th;
    int mag;
    int r;
    deriv = mode[DERIV_BIT];
    s = int'(sample);
    r = 0;
    case (func_t'(mode[1:0]))
      FN_RELU: begin
        if (deriv) begin
          r = (s > 0) ? ONE : 0;
        end else begin
          r = (s > 0) ? s : 0;
        end
      end
      FN_SIGMOID: begin
        sg = sigmoid_of(sample);
        r = deriv ? ((sg * (ONE - sg)) >>> FRAC_BITS) : sg;
      end
      FN_TANH: begin
        dbl = 2 * s;
        if (dbl > 32767) begin
          dbl = 32767;
        end
        if (dbl < -32768) begin
          dbl = -32768;
        end
        th = 2 * sigmoid_of(SAMPLE_W'(dbl)) - ONE;
        mag = (th < 0) ? -th : th;
        r = deriv ? (ONE - ((mag * mag) >>> FRAC_BITS)) : th;
      end
      default: begin
        r = deriv ? ONE : s;
      end
    endcase
    return SAMPLE_W'(r);
  endfunction

  function automatic logic [MODE_W-1:0] make_mode(func_t fn, bit deriv);
    return {deriv, fn};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int pick;
    case ($urandom_range(0, 9))
      6, 7, 8: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
      9: begin
        pick = $urandom_range(0, 8);
        case (pick)
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd16383;
          3: return 16'sd16384;
          4: return -16'sd16384;
          5: return -16'sd16385;
          6: return 16'sd1;
          7: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back('{in_mode, in_sample,
                                    predict_activation(in_mode, in_sample)});
      end
      if ($urandom_range(0, 63) == 0) begin
        in_calm <= !in_calm;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (send_queue.size() != 0) begin
          in_mode   <= send_queue[0].mode;
          in_sample <= send_queue[0].sample;
          in_valid  <= 1'b1;
          in_gap    <= pick_gap(in_calm);
          void'(send_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (error_count < MAX_PRINTS) begin
            $display("%0t: unexpected word, expected none, actual %0d",
                     $time, out_activation_out);
          end
          error_count++;
        end else begin
          if (out_activation_out !== awaited_results[0].value) begin
            if (error_count < MAX_PRINTS) begin
              $display("%0t: mode %0d sample %0d: expected %0d, actual %0d", $time,
                       awaited_results[0].mode, awaited_results[0].sample,
                       awaited_results[0].value, out_activation_out);
            end
            error_count++;
          end
          words_checked++;
          if (awaited_results[0].mode[DERIV_BIT]) begin
            deriv_checked++;
          end
          void'(awaited_results.pop_front());
        end
      end
      if ($urandom_range(0, 63) == 0) begin
        out_calm <= !out_calm;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap(out_calm);
      end
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] edges [3];
    edges = '{-16'sd32768, 16'sd32767, 16'sd0};
    build_sigmoid_rom();

    // Both ends of the sample range and the zero point, for every function
    // and its derivative. The ends also saturate the doubled tanh input.
    for (int f = 0; f < 4; f++) begin
      for (int d = 0; d < 2; d++) begin
        foreach (edges[e]) begin
          send_queue.push_back('{make_mode(func_t'(f), d[0]), edges[e]});
        end
      end
    end
    send_queue.push_back('{make_mode(FN_TANH, 1'b0), 16'sd16384});

    for (int n = 0; n < RAND_WORDS; n++) begin
      send_queue.push_back('{MODE_W'($urandom_range(0, 7)), random_sample()});
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (send_queue.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Checked %0d words over all four functions, %0d of them derivatives,",
             words_checked, deriv_checked);
    $display("with range ends, the zero point and random samples under random gaps.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== activation_function_unit.f =====
design/afu_pkg.sv
design/afu_core.sv
design/activation_function_unit.sv
bench/tb_activation_function_unit.sv
